[rtl/overwrite_oldest_log_ring_top_defines.svh]
// ----------------------------------------------------------------------------
// Overwrite-oldest log ring: assertion macros
// Shared concurrent assertion forms for the ring's RTL files.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_OLDEST_LOG_RING_TOP_DEFINES_SVH
`define OVERWRITE_OLDEST_LOG_RING_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define OLR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olr: implication check failed");

// Antecedent implies consequent in the next cycle.
`define OLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olr: next-cycle check failed");

// Condition must never hold.
`define OLR_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("olr: forbidden condition seen");

`endif

[rtl/olr_pkg.sv]
// ----------------------------------------------------------------------------
// Overwrite-oldest log ring package
// Sizes, register indexes and the types passed between front, queue and back.
// ----------------------------------------------------------------------------
package olr_pkg;

  localparam int BUF_BYTES  = 4 * 1024;
  localparam int READ_MAX   = 64;
  localparam int PTR_W      = $clog2(BUF_BYTES);
  localparam int FILL_W     = $clog2(BUF_BYTES + 1);
  localparam int WANT_W     = $clog2(READ_MAX + 1);
  localparam int COUNT_W    = 13;
  localparam int CLASS_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int MIN_READ_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_MASK = 2'd0,
    CFG_MIN_READ = 2'd1,
    CFG_LOG_OPEN = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  // One queued command: a kept write byte or a read request
  typedef struct packed {
    logic              is_read;
    logic [BYTE_W-1:0] data;
    logic [WANT_W-1:0] want;
  } cmd_t;

  // Configuration effects on the back part
  typedef struct packed {
    logic                  clear_fill;
    logic                  reset_oldest;
    logic [MIN_READ_W-1:0] min_read;
  } cfg_ctl_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_data;
    logic              ready_res;
    logic              last;
  } res_t;

endpackage

[rtl/olr_front.sv]
// ----------------------------------------------------------------------------
// Log ring front end
// Holds the configuration registers, drops filtered writes and saturates
// read counts before queueing commands for the back end.
// ----------------------------------------------------------------------------
module olr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [olr_pkg::CLASS_W-1:0]     msg_class,
  input  logic [olr_pkg::BYTE_W-1:0]      in_byte,
  input  logic [olr_pkg::COUNT_W-1:0]     count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [olr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [olr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            q_push,
  output olr_pkg::cmd_t                   q_cmd,
  input  logic                            q_full,
  output olr_pkg::cfg_ctl_t               ctl
);
  import olr_pkg::*;

  logic [CLASS_W-1:0]    log_mask;
  logic [MIN_READ_W-1:0] min_read;
  logic                  log_open;
  logic                  cfg_wr;
  logic                  keep;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_mask <= '0;
      min_read <= MIN_READ_W'(1);
      log_open <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOG_MASK: log_mask <= cfg_data[CLASS_W-1:0];
        CFG_MIN_READ: min_read <= cfg_data[MIN_READ_W-1:0];
        CFG_LOG_OPEN: log_open <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Any log_open write empties the ring; opening from closed rewinds it
  always_comb begin
    ctl.clear_fill   = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_LOG_OPEN);
    ctl.reset_oldest = ctl.clear_fill && cfg_data[0] && !log_open;
    ctl.min_read     = min_read;
  end

  // Drop writes that are masked, closed, empty or longer than the ring
  always_comb begin
    keep = req_type ||
           (((log_mask & msg_class) != '0) && log_open && (count != '0) &&
            (32'(count) <= 32'(BUF_BYTES)));
    q_cmd.is_read = req_type;
    q_cmd.data    = in_byte;
    q_cmd.want    = (32'(count) > 32'(READ_MAX)) ? WANT_W'(READ_MAX)
                                                 : count[WANT_W-1:0];
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

[rtl/olr_cmdq.sv]
// ----------------------------------------------------------------------------
// Log ring command queue
// Short FIFO that decouples the front end from the ring back end.
// ----------------------------------------------------------------------------
module olr_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  olr_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output olr_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import olr_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   used;

  assign full       = (used == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (used != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

endmodule

[rtl/olr_back.sv]
// ----------------------------------------------------------------------------
// Log ring back end
// Owns the byte ring, its pointers and the read sequencer, and delivers
// results through a two-entry output buffer.
// ----------------------------------------------------------------------------
`include "overwrite_oldest_log_ring_top_defines.svh"

module olr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  olr_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  input  olr_pkg::cfg_ctl_t          ctl,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [olr_pkg::BYTE_W-1:0] out_byte,
  output logic                       has_data,
  output logic                       ready_res,
  output logic                       last
);
  import olr_pkg::*;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_sum(input logic [PTR_W-1:0] a,
                                                input logic [FILL_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + (PTR_W+1)'(b);
    if (32'(s) >= 32'(BUF_BYTES)) begin
      s = s - (PTR_W+1)'(BUF_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [BYTE_W-1:0] ring_mem [BUF_BYTES];
  logic [BYTE_W-1:0] rd_data;

  back_state_t       state, state_next;
  logic [PTR_W-1:0]  oldest, oldest_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [WANT_W-1:0] remain, remain_next;
  logic              pipe_valid;
  logic              pipe_last;

  res_t              out_slot [2];
  logic              out_wr;
  logic              out_rd;
  logic [1:0]        occ;

  logic              pop;
  logic [1:0]        occ_after;
  logic [1:0]        pending;
  logic              room;
  logic              issue;
  logic              issue_last;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              direct_push;
  res_t              direct_res;
  logic              push;
  res_t              push_res;

  logic [MIN_READ_W-1:0] thr;
  logic                  served;
  logic [WANT_W-1:0]     n_bytes;
  logic                  full;

  // Output buffer credit: data in flight from the ring counts as used
  assign pop       = out_valid && out_ready;
  assign occ_after = occ - 2'(pop);
  assign pending   = occ_after + 2'(pipe_valid);
  assign room      = (pending < 2'd2);
  assign full      = (fill == FILL_W'(BUF_BYTES));

  always_comb begin
    thr     = (ctl.min_read == '0) ? MIN_READ_W'(1) : ctl.min_read;
    served  = (32'(fill) >= 32'(thr)) || (32'(fill) >= 32'(q_cmd.want));
    n_bytes = (32'(fill) < 32'(q_cmd.want)) ? fill[WANT_W-1:0] : q_cmd.want;
  end

  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    fill_next   = fill;
    remain_next = remain;
    q_pop       = 1'b0;
    issue       = 1'b0;
    issue_last  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = wrap_sum(oldest, fill);
    direct_push = 1'b0;
    direct_res  = '{out_byte: '0, has_data: 1'b0, ready_res: 1'b0, last: 1'b1};
    case (state)
      BK_IDLE: begin
        if (q_valid && !q_cmd.is_read) begin
          q_pop = 1'b1;
          wr_en = 1'b1;
          if (full) begin
            // Discard the oldest byte; its slot takes the new one
            wr_addr     = oldest;
            oldest_next = wrap_inc(oldest);
          end else begin
            fill_next = fill + 1'b1;
          end
        end else if (q_valid && !pipe_valid && room) begin
          q_pop = 1'b1;
          if (!served) begin
            direct_push = 1'b1;
          end else if (n_bytes == '0) begin
            direct_push          = 1'b1;
            direct_res.ready_res = 1'b1;
          end else begin
            remain_next = n_bytes;
            state_next  = BK_READ;
          end
        end
      end
      BK_READ: begin
        if (room) begin
          issue       = 1'b1;
          issue_last  = (remain == WANT_W'(1));
          oldest_next = wrap_inc(oldest);
          fill_next   = fill - 1'b1;
          remain_next = remain - 1'b1;
          if (issue_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
    if (ctl.clear_fill) begin
      fill_next = '0;
    end
    if (ctl.reset_oldest) begin
      oldest_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= q_cmd.data;
    end
    if (issue) begin
      rd_data <= ring_mem[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      fill       <= '0;
      remain     <= '0;
      pipe_valid <= 1'b0;
      pipe_last  <= 1'b0;
    end else begin
      oldest     <= oldest_next;
      fill       <= fill_next;
      remain     <= remain_next;
      pipe_valid <= issue;
      pipe_last  <= issue_last;
    end
  end

  always_comb begin
    push     = pipe_valid || direct_push;
    push_res = direct_res;
    if (pipe_valid) begin
      push_res = '{out_byte: rd_data, has_data: 1'b1, ready_res: 1'b1,
                   last: pipe_last};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_slot[out_wr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr <= 1'b0;
      out_rd <= 1'b0;
      occ    <= '0;
    end else begin
      if (push) begin
        out_wr <= ~out_wr;
      end
      if (pop) begin
        out_rd <= ~out_rd;
      end
      occ <= occ_after + 2'(push);
    end
  end

  assign out_valid = (occ != '0);
  assign out_byte  = out_slot[out_rd].out_byte;
  assign has_data  = out_slot[out_rd].has_data;
  assign ready_res = out_slot[out_rd].ready_res;
  assign last      = out_slot[out_rd].last;

  `OLR_ASSERT_NEVER(a_fill_range, clk, rst, 32'(fill) > 32'(BUF_BYTES))
  `OLR_ASSERT_NEVER(a_out_credit, clk, rst, (3'(occ) + 3'(pipe_valid)) > 3'd2)
  `OLR_ASSERT_IMP(a_issue_nonempty, clk, rst, issue, fill != '0)
  `OLR_ASSERT_IMP(a_read_remain, clk, rst, state == BK_READ, remain != '0)
  `OLR_ASSERT_NEXT(a_open_rewind, clk, rst, ctl.reset_oldest, oldest == '0 && fill == '0)

endmodule

[rtl/overwrite_oldest_log_ring_top.sv]
// ----------------------------------------------------------------------------
// Overwrite-oldest log ring, top level
// Byte ring for log records with class filtering and thresholded reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): req_type 0 offers one message byte,
//   kept only if msg_class overlaps log_mask, the log is open and count
//   (message length) is 1..4096; a full ring drops its oldest byte first.
//   req_type 1 asks for count bytes (saturated to 64).
//   Output channel (out_valid/out_ready): one beat per byte read, oldest
//   first, last set on the final one; a refused or empty read gives a
//   single beat with has_data 0 and last 1.
//   Config channel (cfg_valid/cfg_ready): index 0 log_mask, 1 min_read,
//   2 log_open; write only while the block is idle.
// Timing: a kept write beat reaches the ring through the command queue;
//   writes sustain one beat per cycle while no read runs, and the back end
//   runs one read at a time. A served read's bytes pass the registered ring
//   read port into the output buffer, one byte per cycle while it has room,
//   set by the single read port; a refused or empty read skips the ring.
// Stall: the output side holds two results; when out_ready is low the
//   read sequencer pauses and the command queue (four deep) backs up into
//   in_ready. Reset empties the ring pointers; memory contents are not
//   cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module overwrite_oldest_log_ring_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [olr_pkg::CLASS_W-1:0]     msg_class,
  input  logic [olr_pkg::BYTE_W-1:0]      in_byte,
  input  logic [olr_pkg::COUNT_W-1:0]     count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [olr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            has_data,
  output logic                            ready_res,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [olr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [olr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import olr_pkg::*;

  // Front to queue
  logic     q_push;
  cmd_t     q_push_cmd;
  logic     q_full;
  // Queue to back
  logic     q_head_valid;
  cmd_t     q_head_cmd;
  logic     q_pop;
  // Configuration effects
  cfg_ctl_t ctl;

  // Accept, filter and classify; hold configuration
  olr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .msg_class (msg_class),
    .in_byte   (in_byte),
    .count     (count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd),
    .q_full    (q_full),
    .ctl       (ctl)
  );

  // Decouple front and back
  olr_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // Store bytes, serve reads
  olr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_head_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .ready_res (ready_res),
    .last      (last)
  );

endmodule

[tb/sv/overwrite_oldest_log_ring_top_test.sv]
// ----------------------------------------------------------------------------
// Overwrite-oldest log ring: self-checking testbench
// Drives write and read requests through the valid/ready input channel and
// sets the registers between phases. A model of the ring
// predicts every result beat, and each beat taken from the output channel
// is compared field by field. Phases: reset state, class and length
// filtering, read threshold, opening and closing, top threshold,
// output back-pressure, then random traffic over several settings.
// ----------------------------------------------------------------------------
module overwrite_oldest_log_ring_top_test;
  import olr_pkg::*;

  // Request kinds on req_type
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  // An index that names no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 32;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int RANDOM_ROUNDS = 4;
  localparam int EXTRA_BYTES   = 40;

  // One input request, field for field as on the ports
  typedef struct {
    req_kind_t           kind;
    logic [CLASS_W-1:0]  msg_class;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } log_req_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  req_type  = 1'b0;
  logic [CLASS_W-1:0]    msg_class = '0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic [COUNT_W-1:0]    count     = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  has_data;
  logic                  ready_res;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Test control: calm switches idling off on both sides, out_hold stalls
  // the receiver for a fixed stretch
  logic        calm     = 1'b0;
  logic        out_hold = 1'b0;
  event        hold_off_go;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Ring image and register copies kept in step with accepted beats
  logic [BYTE_W-1:0]     ring_copy [BUF_BYTES];
  logic [PTR_W-1:0]      oldest_copy   = '0;
  logic [FILL_W-1:0]     fill_copy     = '0;
  logic [CLASS_W-1:0]    mask_copy     = '0;
  logic [MIN_READ_W-1:0] min_read_copy = MIN_READ_W'(1);
  logic                  open_copy     = 1'b0;

  // Result beats still owed by the block, oldest first
  res_t beats_due [$];

  overwrite_oldest_log_ring_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .msg_class (msg_class),
    .in_byte   (in_byte),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .ready_res (ready_res),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic res_t make_beat(input logic [BYTE_W-1:0] b, input logic has,
                                     input logic rdy, input logic lst);
    res_t r;
    r.out_byte  = b;
    r.has_data  = has;
    r.ready_res = rdy;
    r.last      = lst;
    return r;
  endfunction

  // Mirror a register write; opening a closed log also rewinds the oldest
  // pointer, any write of log_open empties the ring
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_LOG_MASK: mask_copy = value[CLASS_W-1:0];
      CFG_MIN_READ: min_read_copy = value[MIN_READ_W-1:0];
      CFG_LOG_OPEN: begin
        if (value[0] && !open_copy) oldest_copy = '0;
        fill_copy = '0;
        open_copy = value[0];
      end
      default: ;
    endcase
  endfunction

  // Work out the beats one accepted request causes and advance the ring image
  function automatic void predict_log_beats(input log_req_t req);
    int unsigned      thr;
    int unsigned      want;
    int unsigned      n;
    logic [PTR_W-1:0] slot;
    if (req.kind == REQ_WRITE) begin
      // drop: class masked off, log closed, empty or oversized message
      if ((mask_copy & req.msg_class) == '0 || !open_copy) return;
      if (req.count == '0 || req.count > BUF_BYTES) return;
      if (fill_copy == BUF_BYTES) begin
        oldest_copy = oldest_copy + 1'b1;
        fill_copy   = FILL_W'(BUF_BYTES - 1);
      end
      slot = oldest_copy + fill_copy[PTR_W-1:0];
      ring_copy[slot] = req.data;
      fill_copy = fill_copy + 1'b1;
      return;
    end
    thr  = (min_read_copy == '0) ? 1 : min_read_copy;
    want = (req.count > READ_MAX) ? READ_MAX : req.count;
    if (fill_copy < thr && fill_copy < want) begin
      beats_due.push_back(make_beat('0, 1'b0, 1'b0, 1'b1));
      return;
    end
    n = (want > fill_copy) ? fill_copy : want;
    if (n == 0) begin
      beats_due.push_back(make_beat('0, 1'b0, 1'b1, 1'b1));
      return;
    end
    for (int i = 0; i < n; i++) begin
      beats_due.push_back(make_beat(ring_copy[oldest_copy], 1'b1, 1'b1, i == n - 1));
      oldest_copy = oldest_copy + 1'b1;
    end
    fill_copy = fill_copy - FILL_W'(n);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random idling, none while calm, held low during a hold-off
  // --------------------------------------------------------------------------
  initial begin : sink
    forever begin
      @(posedge clk);
      if (out_hold) out_ready <= 1'b0;
      else if (calm) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Count out the hold-off in cycles of its own
  initial begin : hold_off
    forever begin
      @(hold_off_go);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  // Check beats at the falling edge: valid, ready and payload are settled and
  // cannot change before the rising edge that takes the beat
  always @(negedge clk) begin : beat_check
    res_t due;
    if (!rst && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: out_byte %0h has_data %0b ready_res %0b last %0b",
               out_byte, has_data, ready_res, last);
        fail_count++;
      end else begin
        due = beats_due.pop_front();
        if (out_byte !== due.out_byte) begin
          $error("out_byte: expected %0h, got %0h", due.out_byte, out_byte);
          fail_count++;
        end
        if (has_data !== due.has_data) begin
          $error("has_data: expected %0b, got %0b", due.has_data, has_data);
          fail_count++;
        end
        if (ready_res !== due.ready_res) begin
          $error("ready_res: expected %0b, got %0b", due.ready_res, ready_res);
          fail_count++;
        end
        if (last !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, last);
          fail_count++;
        end
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("overwrite_oldest_log_ring_top_test NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic log_req_t write_req(input logic [CLASS_W-1:0] cls,
                                         input logic [BYTE_W-1:0] b,
                                         input logic [COUNT_W-1:0] len);
    log_req_t r;
    r.kind      = REQ_WRITE;
    r.msg_class = cls;
    r.data      = b;
    r.count     = len;
    return r;
  endfunction

  function automatic log_req_t read_req(input logic [COUNT_W-1:0] len);
    log_req_t r;
    r.kind      = REQ_READ;
    r.msg_class = $urandom;
    r.data      = BYTE_W'($urandom_range(255));
    r.count     = len;
    return r;
  endfunction

  // Offer one request and predict its beats once it is taken. Valid stays
  // high after acceptance so back-to-back beats need no extra step; drop it
  // only on an idle cycle or in wait_until_quiet.
  task automatic send_request(input log_req_t req);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    req_type  <= req.kind;
    msg_class <= req.msg_class;
    in_byte   <= req.data;
    count     <= req.count;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_log_beats(req);
  endtask

  // Release the input, wait for every owed beat, then let queued writes land
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    apply_reg_write(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: writes whose class passes the mask with a
  // valid length, reads within the saturation range; the rest is noise
  function automatic log_req_t random_request();
    log_req_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) begin
      r = write_req($urandom, BYTE_W'($urandom_range(255)), 1);
      if ($urandom_range(99) < 85 && (r.msg_class & mask_copy) == '0)
        r.msg_class = r.msg_class | mask_copy;
      roll = $urandom_range(99);
      if (roll < 6) r.count = '0;
      else if (roll < 14) r.count = COUNT_W'($urandom_range(BUF_BYTES + 1, 8191));
      else if (roll < 60) r.count = COUNT_W'($urandom_range(1, READ_MAX));
      else r.count = COUNT_W'($urandom_range(1, BUF_BYTES));
    end else begin
      roll = $urandom_range(99);
      if (roll < 10) r = read_req('0);
      else if (roll < 75) r = read_req(COUNT_W'($urandom_range(1, READ_MAX)));
      else r = read_req(COUNT_W'($urandom_range(READ_MAX + 1, 8191)));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight out of reset: log closed, mask clear, empty ring
  task automatic test_reset_state();
    send_request(read_req(5));        // refused: nothing held
    send_request(read_req(0));        // served, but nothing to return
    send_request(write_req('1, 8'h5A, 1));
    send_request(read_req(1));        // the write above was dropped
  endtask

  // Keep only bytes whose class overlaps the mask and whose message fits
  task automatic test_class_and_length_filter();
    wait_until_quiet();
    write_reg(CFG_LOG_MASK, 32'h0000_00F0);
    write_reg(CFG_MIN_READ, 1);
    write_reg(CFG_LOG_OPEN, 1);
    send_request(write_req(32'h0000_000F, 8'h11, 1));     // masked off
    send_request(write_req(32'h0000_0010, 8'h00, 1));
    send_request(write_req('1, 8'hFF, COUNT_W'(BUF_BYTES)));      // longest that fits
    send_request(write_req('1, 8'h22, 0));                        // zero length
    send_request(write_req('1, 8'h33, COUNT_W'(BUF_BYTES + 1)));  // oversized
    send_request(write_req('1, 8'h44, 8191));
    send_request(write_req(32'h8000_0080, 8'hA5, 17));
    send_request(read_req(COUNT_W'(READ_MAX)));
    send_request(read_req(1));
    send_request(read_req(8191));                         // saturates to 64
  endtask

  // Serve on fill reaching min_read or the wanted count; min_read 0 acts as 1
  task automatic test_read_threshold();
    wait_until_quiet();
    write_reg(CFG_MIN_READ, 3);
    send_request(write_req('1, 8'h01, 2));
    send_request(write_req('1, 8'h02, 2));
    send_request(read_req(5));        // refused: below both
    send_request(read_req(2));        // served: fill covers the count
    wait_until_quiet();
    write_reg(CFG_MIN_READ, 0);
    send_request(read_req(1));
    send_request(write_req('1, 8'h7E, 1));
    send_request(read_req(1));
  endtask

  // Any log_open write empties the ring; reopening rewinds the oldest pointer
  task automatic test_open_and_close();
    wait_until_quiet();
    write_reg(CFG_NO_REG, '1);
    send_request(write_req('1, 8'hC1, 3));
    send_request(write_req('1, 8'hC2, 3));
    send_request(write_req('1, 8'hC3, 3));
    wait_until_quiet();
    write_reg(CFG_LOG_OPEN, 1);       // already open: drop the held bytes only
    send_request(write_req('1, 8'hD1, 2));
    send_request(write_req('1, 8'hD2, 2));
    send_request(read_req(COUNT_W'(READ_MAX)));
    wait_until_quiet();
    write_reg(CFG_LOG_OPEN, 0);
    send_request(write_req('1, 8'hE1, 1));
    send_request(read_req(0));
    wait_until_quiet();
    write_reg(CFG_LOG_OPEN, 1);
    send_request(write_req('1, 8'hE2, 1));
    send_request(read_req(1));
  endtask

  // Top threshold: reads are served only once the fill covers the count
  task automatic test_top_threshold();
    wait_until_quiet();
    write_reg(CFG_LOG_MASK, '1);
    write_reg(CFG_MIN_READ, BUF_BYTES);
    for (int i = 0; i < 10; i++)
      send_request(write_req($urandom | 1, BYTE_W'($urandom_range(255)),
                             COUNT_W'($urandom_range(1, 64))));
    send_request(read_req(COUNT_W'(READ_MAX)));  // refused: far below threshold
    send_request(read_req(10));                  // served: fill covers the count
    for (int i = 0; i < EXTRA_BYTES; i++)
      send_request(write_req($urandom | 1, BYTE_W'($urandom_range(255)),
                             COUNT_W'($urandom_range(1, BUF_BYTES))));
    for (int i = 0; i < 3; i++)
      send_request(read_req(COUNT_W'(READ_MAX)));
    send_request(read_req(8191));
    wait_until_quiet();
    write_reg(CFG_LOG_OPEN, 0);
  endtask

  // Stall the receiver while reads and writes keep coming, so the result
  // buffer and the command queue fill and in_ready drops
  task automatic test_output_backpressure();
    wait_until_quiet();
    write_reg(CFG_MIN_READ, 1);
    write_reg(CFG_LOG_OPEN, 1);
    for (int i = 0; i < 24; i++)
      send_request(write_req('1, BYTE_W'($urandom_range(255)), 24));
    -> hold_off_go;
    for (int i = 0; i < 4; i++) begin
      send_request(read_req(16));
      for (int j = 0; j < 3; j++)
        send_request(write_req('1, BYTE_W'($urandom_range(255)), 5));
    end
  endtask

  // Random traffic over several register settings; the first round runs
  // with no idling on either side
  task automatic test_random_traffic();
    int per_round;
    per_round = RANDOM_ITEMS / RANDOM_ROUNDS;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      wait_until_quiet();
      case (round)
        0: begin
          write_reg(CFG_LOG_MASK, '1);
          write_reg(CFG_MIN_READ, 1);
        end
        1: begin
          write_reg(CFG_LOG_MASK, $urandom);
          write_reg(CFG_MIN_READ, 0);
        end
        2: begin
          write_reg(CFG_LOG_MASK, $urandom);
          write_reg(CFG_MIN_READ, $urandom_range(2, 24));
        end
        default: begin
          write_reg(CFG_LOG_MASK, $urandom);
          write_reg(CFG_MIN_READ, $urandom_range(1, BUF_BYTES));
        end
      endcase
      write_reg(CFG_LOG_OPEN, 1);
      calm = (round == 0);
      for (int i = 0; i < per_round; i++)
        send_request(random_request());
      calm = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_class_and_length_filter();
    test_read_threshold();
    test_open_and_close();
    test_top_threshold();
    test_output_backpressure();
    test_random_traffic();
    wait_until_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("overwrite_oldest_log_ring_top_test OK");
    else
      $display("overwrite_oldest_log_ring_top_test NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/olr_pkg.sv
rtl/olr_front.sv
rtl/olr_cmdq.sv
rtl/olr_back.sv
rtl/overwrite_oldest_log_ring_top.sv
tb/sv/overwrite_oldest_log_ring_top_test.sv
